// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define SKT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// The condition must never be seen at a rising clock edge outside reset.
`define SKT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/core/skt_pkg.sv =====
// Package with the types, codes and defaults of the sorted key table.
package skt_pkg;

    // Default number of table entries.
    localparam int DEPTH_DEF = 256;

    // Operation codes.
    localparam logic OP_SEARCH = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // One request item.
    typedef struct packed {
        logic        op;
        logic [31:0] key;
        logic [8:0]  position;
        logic [31:0] payload_addr;
        logic [31:0] payload_len;
    } t_req;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  index;
        logic [31:0] found_addr;
        logic [31:0] found_len;
        logic [8:0]  entry_count;
    } t_rsp;

    // One stored table entry.
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] addr;
        logic [31:0] len;
    } t_entry;

    // Compare flags that a cell reports.
    typedef struct packed {
        logic lt;   // valid entry with a key below the search key
        logic hit;  // this cell is the lower-bound slot
        logic eq;   // valid entry with a key equal to the search key
    } t_cell_flags;

endpackage

// ===== rtl/core/skt_cell.sv =====
// One table cell: stores an entry, compares it with the key, shifts on insert.
module skt_cell (
    input  logic                 i_clk,
    input  logic [31:0]          i_key,
    input  logic                 i_valid,
    input  logic                 i_lt_left,
    input  skt_pkg::t_entry      i_left,
    input  skt_pkg::t_entry      i_new,
    input  logic                 i_ins,
    output skt_pkg::t_entry      o_entry,
    output skt_pkg::t_cell_flags o_flags
);

    skt_pkg::t_entry r_entry;
    skt_pkg::t_entry n_entry;

    // Compare the stored key with the broadcast key.
    always_comb begin
        o_flags.lt  = i_valid && (r_entry.key < i_key);
        o_flags.eq  = i_valid && (r_entry.key == i_key);
        o_flags.hit = i_lt_left && !o_flags.lt;
    end

    // On insert the slot cell takes the new entry and cells above it take
    // the entry of their left neighbor.
    always_comb begin
        n_entry = r_entry;
        if (i_ins) begin
            if (o_flags.hit) begin
                n_entry = i_new;
            end else if (!o_flags.lt) begin
                n_entry = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/core/skt_select.sv =====
// Encodes the lower-bound slot of the cell row and selects its payload.
module skt_select #(
    parameter int DEPTH = skt_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic [DEPTH-1:0]  i_hit,
    input  logic [DEPTH-1:0]  i_eq,
    input  logic              i_all_lt,
    input  skt_pkg::t_entry   i_entries [DEPTH],
    output logic [CW-1:0]     o_slot,
    output logic              o_found,
    output logic [31:0]       o_addr,
    output logic [31:0]       o_len
);

    // Exactly one cell flags the slot unless every entry is below the key,
    // so plain OR trees encode the slot and pick its payload.
    always_comb begin
        o_slot = i_all_lt ? CW'(DEPTH) : '0;
        o_addr = '0;
        o_len  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i_hit[i]) begin
                o_slot = o_slot | CW'(i);
                o_addr = o_addr | i_entries[i].addr;
                o_len  = o_len | i_entries[i].len;
            end
        end
    end

    // The key is present when the slot cell holds it.
    assign o_found = |(i_hit & i_eq);

endmodule

// ===== rtl/core/sorted_key_table.sv =====
// Top level of the sorted key table: a row of entry cells and its control.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+--------------------
//   request   | start, busy           | i_req  (skt_pkg::t_req)
//   result    | o_done (one cycle)    | o_rsp  (skt_pkg::t_rsp)
//
// The cycle after acceptance holds busy while the cells compare the key in
// parallel, the slot is encoded and any insert shift is written into the
// cell row; the result strobe follows in the next cycle, when a new item
// can already be accepted. The slot encoder over the row sets the length
// of the busy cycle. Reset empties the table at once.
// The receiver cannot stall results; each result is shown for one cycle.
module sorted_key_table #(
    parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  skt_pkg::t_req i_req,
    output logic          o_done,
    output skt_pkg::t_rsp o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 9) ? CW : 9;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    skt_pkg::t_req r_req;
    skt_pkg::t_rsp r_rsp;
    skt_pkg::t_rsp n_rsp;

    skt_pkg::t_entry      w_entries [DEPTH];
    skt_pkg::t_cell_flags w_flags   [DEPTH];
    logic [DEPTH-1:0]     w_hit;
    logic [DEPTH-1:0]     w_eq;
    logic [CW-1:0]        w_slot;
    logic                 w_found;
    logic [31:0]          w_addr;
    logic [31:0]          w_len;
    logic                 w_pos_ok;
    logic                 w_full;
    logic                 w_ins;
    skt_pkg::t_entry      w_new;

    assign w_new = '{key: r_req.key, addr: r_req.payload_addr, len: r_req.payload_len};

    // Row of entry cells; each passes its compare flag and entry rightward.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic            w_valid;
        logic            w_lt_left;
        skt_pkg::t_entry w_left;

        assign w_valid = r_count > CW'(g);
        if (g == 0) begin : g_first
            assign w_lt_left = 1'b1;
            assign w_left    = w_new;
        end else begin : g_rest
            assign w_lt_left = w_flags[g-1].lt;
            assign w_left    = w_entries[g-1];
        end

        skt_cell u_cell (
            .i_clk     (i_clk),
            .i_key     (r_req.key),
            .i_valid   (w_valid),
            .i_lt_left (w_lt_left),
            .i_left    (w_left),
            .i_new     (w_new),
            .i_ins     (w_ins),
            .o_entry   (w_entries[g]),
            .o_flags   (w_flags[g])
        );

        assign w_hit[g] = w_flags[g].hit;
        assign w_eq[g]  = w_flags[g].eq;
    end

    skt_select #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_select (
        .i_hit     (w_hit),
        .i_eq      (w_eq),
        .i_all_lt  (w_flags[DEPTH-1].lt),
        .i_entries (w_entries),
        .o_slot    (w_slot),
        .o_found   (w_found),
        .o_addr    (w_addr),
        .o_len     (w_len)
    );

    // An insert keeps the order only when its position is the lower-bound
    // slot of its key and that slot does not already hold the key.
    assign w_pos_ok = (PW'(w_slot) == PW'(r_req.position)) && !w_found;
    assign w_full   = r_count == CW'(DEPTH);
    assign w_ins    = r_busy && (r_req.op == skt_pkg::OP_INSERT) && w_pos_ok && !w_full;
    assign n_count  = w_ins ? r_count + CW'(1) : r_count;

    // Result of the item under work.
    always_comb begin
        n_rsp             = '0;
        n_rsp.entry_count = 9'(n_count);
        if (r_req.op == skt_pkg::OP_SEARCH) begin
            n_rsp.index = 9'(w_slot);
            if (w_found) begin
                n_rsp.status     = skt_pkg::ST_OK;
                n_rsp.found_addr = w_addr;
                n_rsp.found_len  = w_len;
            end else begin
                n_rsp.status = skt_pkg::ST_ABSENT;
            end
        end else begin
            n_rsp.index = r_req.position;
            if (!w_pos_ok) begin
                n_rsp.status = skt_pkg::ST_BADPOS;
            end else if (w_full) begin
                n_rsp.status = skt_pkg::ST_FULL;
            end else begin
                n_rsp.status = skt_pkg::ST_OK;
            end
        end
    end

    // Control: accept, work while busy, then a one-cycle result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= r_busy;
            if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end else if (start) begin
                r_busy <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_req <= i_req;
        end
        if (r_busy) begin
            r_rsp <= n_rsp;
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== rtl/core/skt_checker.sv =====
// Port-level checker for the sorted key table and its bind statement.
`include "assert_macros.svh"

module skt_checker #(
    parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input skt_pkg::t_req i_req,
    input logic          o_done,
    input skt_pkg::t_rsp o_rsp
);

    // An accepted item holds busy for one cycle, then its result follows.
    `SKT_ASSERT(a_accept_timing, i_clk, i_rst_n, start && !busy |=> busy ##1 o_done, "item result not on time")

    // A result is shown only once the table is free again.
    `SKT_ASSERT_NEVER(a_done_busy, i_clk, i_rst_n, o_done && busy, "result while busy")

    // Payload fields are zero unless a search found its key.
    `SKT_ASSERT(a_payload_zero, i_clk, i_rst_n, o_done && o_rsp.status != skt_pkg::ST_OK |-> o_rsp.found_addr == 32'd0 && o_rsp.found_len == 32'd0, "payload set on a miss")

    // A full table reports the whole depth as its entry count.
    `SKT_ASSERT(a_full_count, i_clk, i_rst_n, o_done && o_rsp.status == skt_pkg::ST_FULL |-> o_rsp.entry_count == 9'(DEPTH), "full status with wrong count")

    // The request port stays unused by the checks above but is watched.
    `SKT_ASSERT_NEVER(a_req_known, i_clk, i_rst_n, start && !busy && $isunknown(i_req.op), "unknown operation")

endmodule

bind sorted_key_table skt_checker #(
    .DEPTH (DEPTH)
) u_skt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

// ===== test/sorted_key_table_tb.sv =====
// Self-checking testbench for the sorted key table: directed and random items.
`timescale 1ns / 1ps

module sorted_key_table_tb;

    localparam int TABLE_DEPTH = skt_pkg::DEPTH_DEF;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    skt_pkg::t_req i_req;
    logic          o_done;
    skt_pkg::t_rsp o_rsp;

    // Mirror of the table contents as seen by the checker.
    logic [31:0] tbl_keys [TABLE_DEPTH];
    logic [31:0] tbl_addrs [TABLE_DEPTH];
    logic [31:0] tbl_lens [TABLE_DEPTH];
    int tbl_count = 0;

    skt_pkg::t_rsp expected_rsps [$];
    int error_count = 0;
    bit idle_on = 1'b0;

    sorted_key_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Lower bound: the first slot whose key is not below k.
    function automatic int first_not_below(input logic [31:0] k);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_keys[i] >= k) begin
                return i;
            end
        end
        return tbl_count;
    endfunction

    // Applies one item to the mirrored table and returns the answer it must give.
    function automatic skt_pkg::t_rsp table_answer(input skt_pkg::t_req r);
        skt_pkg::t_rsp rsp;
        int slot;
        int p;
        rsp = '0;
        if (r.op == skt_pkg::OP_SEARCH) begin
            slot = first_not_below(r.key);
            rsp.index = slot[8:0];
            if (slot < tbl_count && tbl_keys[slot] == r.key) begin
                rsp.status = skt_pkg::ST_OK;
                rsp.found_addr = tbl_addrs[slot];
                rsp.found_len = tbl_lens[slot];
            end else begin
                rsp.status = skt_pkg::ST_ABSENT;
            end
        end else begin
            p = int'(r.position);
            rsp.index = r.position;
            // Slot and key order are checked before the free room.
            if (p > tbl_count || (p > 0 && r.key <= tbl_keys[p - 1]) ||
                    (p < tbl_count && r.key >= tbl_keys[p])) begin
                rsp.status = skt_pkg::ST_BADPOS;
            end else if (tbl_count >= TABLE_DEPTH) begin
                rsp.status = skt_pkg::ST_FULL;
            end else begin
                for (int i = tbl_count; i > p; i--) begin
                    tbl_keys[i] = tbl_keys[i - 1];
                    tbl_addrs[i] = tbl_addrs[i - 1];
                    tbl_lens[i] = tbl_lens[i - 1];
                end
                tbl_keys[p] = r.key;
                tbl_addrs[p] = r.payload_addr;
                tbl_lens[p] = r.payload_len;
                tbl_count++;
                rsp.status = skt_pkg::ST_OK;
            end
        end
        rsp.entry_count = tbl_count[8:0];
        return rsp;
    endfunction

    // An insert of a random key, at times one above a stored key, at the slot where it belongs.
    function automatic skt_pkg::t_req well_formed_insert();
        skt_pkg::t_req r;
        r.op = skt_pkg::OP_INSERT;
        r.key = $urandom();
        if (tbl_count > 0 && $urandom_range(0, 3) == 0) begin
            r.key = tbl_keys[$urandom_range(0, tbl_count - 1)] + 32'd1;
        end
        r.position = 9'(first_not_below(r.key));
        r.payload_addr = $urandom();
        r.payload_len = $urandom();
        return r;
    endfunction

    // Mix of searches, good inserts and broken inserts.
    function automatic skt_pkg::t_req random_request();
        skt_pkg::t_req r;
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        r.op = skt_pkg::OP_SEARCH;
        r.key = $urandom();
        r.position = 9'($urandom());
        r.payload_addr = $urandom();
        r.payload_len = $urandom();
        idx = (tbl_count > 0) ? int'($urandom_range(0, tbl_count - 1)) : 0;
        if (pick < 30) begin
            r = well_formed_insert();
        end else if (pick < 60) begin
            if (tbl_count > 0) begin
                r.key = tbl_keys[idx];
            end
        end else if (pick < 75) begin
            // Keys right next to stored ones.
            if (tbl_count > 0) begin
                r.key = $urandom_range(0, 1) ? tbl_keys[idx] + 32'd1 : tbl_keys[idx] - 32'd1;
            end
        end else if (pick < 92) begin
            r.op = skt_pkg::OP_INSERT;
            if ($urandom_range(0, 1)) begin
                r.position = 9'($urandom_range(0, tbl_count));
            end
        end else begin
            // Duplicate key at one of the two slots around its twin.
            r.op = skt_pkg::OP_INSERT;
            if (tbl_count > 0) begin
                r.key = tbl_keys[idx];
                r.position = 9'(idx + $urandom_range(0, 1));
            end
        end
        return r;
    endfunction

    function automatic skt_pkg::t_req make_request(input logic op, input logic [31:0] key,
                                                   input logic [8:0] position,
                                                   input logic [31:0] addr,
                                                   input logic [31:0] len);
        skt_pkg::t_req r;
        r.op = op;
        r.key = key;
        r.position = position;
        r.payload_addr = addr;
        r.payload_len = len;
        return r;
    endfunction

    // Presents one item and returns at the edge that accepts it.
    task automatic send_item(input skt_pkg::t_req r);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        expected_rsps.push_back(table_answer(r));
    endtask

    // Random burst of idle cycles on the request side.
    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // Each result strobe is matched against the oldest expected answer.
    always @(posedge i_clk) begin : result_check
        skt_pkg::t_rsp want;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_rsps.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none actual %h", $time, o_rsp);
            end else begin
                want = expected_rsps.pop_front();
                compare_field("status", 32'(want.status), 32'(o_rsp.status));
                compare_field("index", 32'(want.index), 32'(o_rsp.index));
                compare_field("found_addr", want.found_addr, o_rsp.found_addr);
                compare_field("found_len", want.found_len, o_rsp.found_len);
                compare_field("entry_count", 32'(want.entry_count), 32'(o_rsp.entry_count));
            end
        end
    end

    // Searches and rejected inserts on the empty table.
    task automatic test_empty_table();
        send_item(make_request(skt_pkg::OP_SEARCH, 32'h0, 9'd0, 32'h0, 32'h0));
        send_item(make_request(skt_pkg::OP_SEARCH, 32'hFFFF_FFFF, 9'h1FF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_request(skt_pkg::OP_INSERT, 32'h10, 9'd1, 32'h1, 32'h1));
        send_item(make_request(skt_pkg::OP_INSERT, 32'h10, 9'h1FF, 32'h1, 32'h1));
    endtask

    // Extreme keys and payloads, order violations and duplicates.
    task automatic test_key_extremes();
        send_item(make_request(skt_pkg::OP_INSERT, 32'h0, 9'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_request(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 9'd1, 32'h0, 32'h0));
        send_item(make_request(skt_pkg::OP_INSERT, 32'h0, 9'd1, 32'h5, 32'h5));
        send_item(make_request(skt_pkg::OP_INSERT, 32'h0, 9'd0, 32'h5, 32'h5));
        send_item(make_request(skt_pkg::OP_INSERT, 32'h5, 9'd0, 32'h5, 32'h5));
        send_item(make_request(skt_pkg::OP_INSERT, 32'h7, 9'd2, 32'h5, 32'h5));
        send_item(make_request(skt_pkg::OP_INSERT, 32'h7, 9'd1, 32'hA5A5_5A5A, 32'h0000_0100));
        send_item(make_request(skt_pkg::OP_SEARCH, 32'h0, 9'd0, 32'h0, 32'h0));
        send_item(make_request(skt_pkg::OP_SEARCH, 32'hFFFF_FFFF, 9'd0, 32'h0, 32'h0));
        send_item(make_request(skt_pkg::OP_SEARCH, 32'h7, 9'd0, 32'h0, 32'h0));
        send_item(make_request(skt_pkg::OP_SEARCH, 32'h6, 9'd0, 32'h0, 32'h0));
        send_item(make_request(skt_pkg::OP_SEARCH, 32'h8, 9'd0, 32'h0, 32'h0));
    endtask

    // Random items with idle bursts switched on and off in stretches.
    task automatic test_random_mix(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                idle_on = 1'($urandom_range(0, 1));
            end
            send_item(random_request());
            idle_gap();
        end
    endtask

    // The sender holds off until every answer is back.
    task automatic test_drain_pause();
        start <= 1'b0;
        while (expected_rsps.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Fills the table, then tries valid and invalid inserts on it.
    task automatic test_full_table();
        skt_pkg::t_req r;
        int gap_at;
        idle_on = 1'b1;
        while (tbl_count < TABLE_DEPTH) begin
            r = ($urandom_range(0, 3) == 0) ? random_request() : well_formed_insert();
            send_item(r);
            idle_gap();
        end
        gap_at = 0;
        for (int p = 1; p < tbl_count; p++) begin
            if (gap_at == 0 && tbl_keys[p] - tbl_keys[p - 1] > 32'd1) begin
                gap_at = p;
            end
        end
        // A well-ordered insert into a full table is refused for room.
        if (gap_at > 0) begin
            send_item(make_request(skt_pkg::OP_INSERT, tbl_keys[gap_at - 1] + 32'd1,
                                   9'(gap_at), $urandom(), $urandom()));
            send_item(make_request(skt_pkg::OP_SEARCH, tbl_keys[gap_at - 1] + 32'd1, 9'd0,
                                   32'h0, 32'h0));
        end
        send_item(make_request(skt_pkg::OP_INSERT, 32'hFFFF_FFFE, 9'd256, 32'h1, 32'h1));
        send_item(make_request(skt_pkg::OP_INSERT, 32'h1234_5678, 9'h1FF, 32'h1, 32'h1));
        send_item(make_request(skt_pkg::OP_SEARCH, tbl_keys[TABLE_DEPTH - 1], 9'd0,
                               32'h0, 32'h0));
    endtask

    // Back-to-back items with no idling.
    task automatic test_tail(input int n);
        idle_on = 1'b0;
        for (int i = 0; i < n; i++) begin
            send_item(random_request());
        end
    endtask

    task automatic finish_run();
        int waited;
        start <= 1'b0;
        waited = 0;
        while (expected_rsps.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (expected_rsps.size() != 0) begin
            error_count++;
            $display("%0t: results missing, expected %0d more actual 0", $time,
                     expected_rsps.size());
        end
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    endtask

    // Test sequence.
    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_key_extremes();
        test_random_mix(600);
        test_drain_pause();
        test_full_table();
        test_tail(800);
        finish_run();
    end

endmodule
